// File: rtl/core/spq_pkg.sv
// Package with shared constants, command codes and the cell control type.
`timescale 1ns / 1ps
package spq_pkg;

   localparam int DEPTH = 16;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int KEY_W = 32;
   localparam int TAG_W = 16;
   localparam int CMD_W = 2;
   localparam int CAP_W = 5;
   localparam int OCC_W = 5;
   localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT = 2'd0,
      CMD_SERVE  = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_NOP    = 2'd3
   } cmd_type;

   typedef struct packed {
      logic             ins_en;
      logic             srv_en;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } cell_ctrl_type;

endpackage

// File: rtl/core/spq_cell.sv
// One slot of the sorted chain: compares against the broadcast key and shifts.
`timescale 1ns / 1ps
module spq_cell (
   input  logic                       clock,
   input  spq_pkg::cell_ctrl_type     ctrl,
   input  logic                       occupied,
   input  logic                       prev_le,
   input  logic [spq_pkg::KEY_W-1:0]  prev_key,
   input  logic [spq_pkg::TAG_W-1:0]  prev_tag,
   input  logic [spq_pkg::KEY_W-1:0]  next_key,
   input  logic [spq_pkg::TAG_W-1:0]  next_tag,
   output logic                       le,
   output logic [spq_pkg::KEY_W-1:0]  key,
   output logic [spq_pkg::TAG_W-1:0]  tag
);
   import spq_pkg::*;

   logic [KEY_W-1:0] key_ff, key_in;
   logic [TAG_W-1:0] tag_ff, tag_in;

   assign le  = occupied && (key_ff <= ctrl.key);
   assign key = key_ff;
   assign tag = tag_ff;

   always_comb begin
      key_in = key_ff;
      tag_in = tag_ff;
      if (ctrl.ins_en) begin
         if (!le) begin
            if (prev_le) begin
               key_in = ctrl.key;
               tag_in = ctrl.tag;
            end else begin
               key_in = prev_key;
               tag_in = prev_tag;
            end
         end
      end else if (ctrl.srv_en) begin
         key_in = next_key;
         tag_in = next_tag;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      tag_ff <= tag_in;
   end

endmodule

// File: rtl/core/sorted_priority_queue_top.sv
// Top level of the sorted priority queue: command decode, cell chain and result register.
`timescale 1ns / 1ps
// The queue holds up to 16 entries (key, tag) sorted by ascending key in a chain
// of cells; every cell compares its key with the broadcast key and shifts toward
// its neighbor in the same cycle, so a new command word (insert, serve, clear)
// is taken every cycle while the result register is free or being drained.
// The result register sits between the two channels.
// Equal keys leave in arrival order. Capacity is written through csr_wr_en and
// csr_wr_data, saturates at 16, and resets to 16.
module sorted_priority_queue_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  logic [spq_pkg::CAP_W-1:0]   csr_wr_data,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [spq_pkg::CMD_W-1:0]   req_cmd,
   input  logic [spq_pkg::KEY_W-1:0]   req_key,
   input  logic [spq_pkg::TAG_W-1:0]   req_tag,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic                        rsp_accepted,
   output logic                        rsp_served_valid,
   output logic [spq_pkg::KEY_W-1:0]   rsp_served_key,
   output logic [spq_pkg::TAG_W-1:0]   rsp_served_tag,
   output logic [spq_pkg::KEY_W-1:0]   rsp_head_key,
   output logic [spq_pkg::TAG_W-1:0]   rsp_head_tag,
   output logic [spq_pkg::OCC_W-1:0]   rsp_occupancy,
   output logic                        rsp_is_full,
   output logic                        rsp_is_empty
);
   import spq_pkg::*;

   logic [CAP_W-1:0] cap_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff;
   logic             accepted_ff, served_valid_ff, full_ff, empty_ff;
   logic [KEY_W-1:0] served_key_ff, head_key_ff, head_key_in;
   logic [TAG_W-1:0] served_tag_ff, head_tag_ff, head_tag_in;
   logic [OCC_W-1:0] occ_ff;

   logic             step, is_ins, is_srv, is_clr;
   logic             full_now, full_next;
   int unsigned      eff_cap;
   cell_ctrl_type    ctrl;

   logic             cell_le  [DEPTH];
   logic [KEY_W-1:0] cell_key [DEPTH];
   logic [TAG_W-1:0] cell_tag [DEPTH];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign step      = req_valid && req_ready;

   always_comb begin
      is_ins = 1'b0;
      is_srv = 1'b0;
      is_clr = 1'b0;
      unique case (cmd_type'(req_cmd))
         CMD_INSERT: is_ins = 1'b1;
         CMD_SERVE:  is_srv = 1'b1;
         CMD_CLEAR:  is_clr = 1'b1;
         default:    ;
      endcase
   end

   assign eff_cap  = (32'(cap_ff) > DEPTH) ? DEPTH : 32'(cap_ff);
   assign full_now = 32'(count_ff) >= eff_cap;

   assign ctrl.ins_en = step && is_ins && !full_now;
   assign ctrl.srv_en = step && is_srv && (count_ff != '0);
   assign ctrl.key    = req_key;
   assign ctrl.tag    = req_tag;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic             occ;
      logic             p_le;
      logic [KEY_W-1:0] p_key, n_key;
      logic [TAG_W-1:0] p_tag, n_tag;

      assign occ = CNT_W'(i) < count_ff;
      if (i == 0) begin : g_first
         assign p_le  = 1'b1;
         assign p_key = '0;
         assign p_tag = '0;
      end else begin : g_mid
         assign p_le  = cell_le[i-1];
         assign p_key = cell_key[i-1];
         assign p_tag = cell_tag[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign n_key = cell_key[i];
         assign n_tag = cell_tag[i];
      end else begin : g_inner
         assign n_key = cell_key[i+1];
         assign n_tag = cell_tag[i+1];
      end

      spq_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .occupied (occ),
         .prev_le  (p_le),
         .prev_key (p_key),
         .prev_tag (p_tag),
         .next_key (n_key),
         .next_tag (n_tag),
         .le       (cell_le[i]),
         .key      (cell_key[i]),
         .tag      (cell_tag[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.srv_en) begin
         count_in = count_ff - CNT_W'(1);
      end else if (step && is_clr) begin
         count_in = '0;
      end
   end

   always_comb begin
      head_key_in = cell_key[0];
      head_tag_in = cell_tag[0];
      if (ctrl.ins_en && !cell_le[0]) begin
         head_key_in = req_key;
         head_tag_in = req_tag;
      end else if (ctrl.srv_en) begin
         head_key_in = (DEPTH > 1) ? cell_key[(DEPTH > 1) ? 1 : 0] : '0;
         head_tag_in = (DEPTH > 1) ? cell_tag[(DEPTH > 1) ? 1 : 0] : '0;
      end
      if (count_in == '0) begin
         head_key_in = '0;
         head_tag_in = '0;
      end
   end

   assign full_next = 32'(count_in) >= eff_cap;

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         count_ff <= count_in;
         if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         accepted_ff     <= ctrl.ins_en;
         served_valid_ff <= ctrl.srv_en;
         served_key_ff   <= ctrl.srv_en ? cell_key[0] : '0;
         served_tag_ff   <= ctrl.srv_en ? cell_tag[0] : '0;
         head_key_ff     <= head_key_in;
         head_tag_ff     <= head_tag_in;
         occ_ff          <= OCC_W'(count_in);
         full_ff         <= full_next;
         empty_ff        <= (count_in == '0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_accepted     = accepted_ff;
   assign rsp_served_valid = served_valid_ff;
   assign rsp_served_key   = served_key_ff;
   assign rsp_served_tag   = served_tag_ff;
   assign rsp_head_key     = head_key_ff;
   assign rsp_head_tag     = head_tag_ff;
   assign rsp_occupancy    = occ_ff;
   assign rsp_is_full      = full_ff;
   assign rsp_is_empty     = empty_ff;

endmodule

// File: bench/tb_sorted_priority_queue_top.sv
// Self-checking testbench for the sorted priority queue: opening table, random phases per capacity.
`timescale 1ns / 1ps
module tb_sorted_priority_queue_top;
   import spq_pkg::*;

   localparam int OPENING_ROWS = 17;
   localparam int PHASES = 12;
   localparam int WORDS_PER_PHASE = 95;
   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      cmd_type          cmd;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] tag;
   } queue_op_type;

   typedef struct packed {
      logic             accepted;
      logic             served_valid;
      logic [KEY_W-1:0] served_key;
      logic [TAG_W-1:0] served_tag;
      logic [KEY_W-1:0] head_key;
      logic [TAG_W-1:0] head_tag;
      logic [OCC_W-1:0] occupancy;
      logic             is_full;
      logic             is_empty;
   } queue_status_type;

   typedef struct packed {
      queue_op_type     op;
      logic             typed;
      queue_status_type status;
   } opening_row_type;

   logic clock;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [CAP_W-1:0] csr_wr_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   cmd_type req_cmd = CMD_NOP;
   logic [KEY_W-1:0] req_key = '0;
   logic [TAG_W-1:0] req_tag = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_accepted;
   logic rsp_served_valid;
   logic [KEY_W-1:0] rsp_served_key;
   logic [TAG_W-1:0] rsp_served_tag;
   logic [KEY_W-1:0] rsp_head_key;
   logic [TAG_W-1:0] rsp_head_tag;
   logic [OCC_W-1:0] rsp_occupancy;
   logic rsp_is_full;
   logic rsp_is_empty;

   logic [KEY_W-1:0] held_keys [DEPTH];
   logic [TAG_W-1:0] held_tags [DEPTH];
   int held_count = 0;
   logic [CAP_W-1:0] model_capacity = CAP_RESET;

   queue_status_type pending_status [$];
   int mismatches = 0;
   int idle_cycles = 0;
   int ready_hold = 0;
   bit steady = 1'b0;

   logic [CAP_W-1:0] phase_caps [PHASES] = '{
      5'd31, 5'd1, 5'd0, 5'd2, 5'd16, 5'd5, 5'd17, 5'd8, 5'd0, 5'd12, 5'd3, 5'd16
   };

   opening_row_type opening_ops [OPENING_ROWS] = '{
      '{'{CMD_SERVE, 32'h0000_0000, 16'h0000}, 1'b1,
        '{1'b0, 1'b0, 32'h0, 16'h0, 32'h0, 16'h0, 5'd0, 1'b0, 1'b1}},
      '{'{CMD_NOP, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1,
        '{1'b0, 1'b0, 32'h0, 16'h0, 32'h0, 16'h0, 5'd0, 1'b0, 1'b1}},
      '{'{CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF}, 1'b1,
        '{1'b1, 1'b0, 32'h0, 16'h0, 32'hFFFF_FFFF, 16'hFFFF, 5'd1, 1'b0, 1'b0}},
      '{'{CMD_INSERT, 32'h0000_0000, 16'h0000}, 1'b1,
        '{1'b1, 1'b0, 32'h0, 16'h0, 32'h0, 16'h0, 5'd2, 1'b0, 1'b0}},
      '{'{CMD_INSERT, 32'h0000_0005, 16'h1111}, 1'b0, '0},
      '{'{CMD_INSERT, 32'h0000_0005, 16'h2222}, 1'b0, '0},
      '{'{CMD_INSERT, 32'h0000_0005, 16'h3333}, 1'b0, '0},
      '{'{CMD_INSERT, 32'hFFFF_FFFF, 16'h0001}, 1'b0, '0},
      '{'{CMD_SERVE, 32'h0000_0000, 16'h0000}, 1'b1,
        '{1'b0, 1'b1, 32'h0, 16'h0, 32'h5, 16'h1111, 5'd5, 1'b0, 1'b0}},
      '{'{CMD_SERVE, 32'hFFFF_FFFF, 16'hFFFF}, 1'b0, '0},
      '{'{CMD_SERVE, 32'h0000_0000, 16'h0000}, 1'b0, '0},
      '{'{CMD_NOP, 32'h1234_5678, 16'hA5A5}, 1'b0, '0},
      '{'{CMD_CLEAR, 32'hAAAA_AAAA, 16'h5555}, 1'b1,
        '{1'b0, 1'b0, 32'h0, 16'h0, 32'h0, 16'h0, 5'd0, 1'b0, 1'b1}},
      '{'{CMD_SERVE, 32'h5555_5555, 16'hAAAA}, 1'b1,
        '{1'b0, 1'b0, 32'h0, 16'h0, 32'h0, 16'h0, 5'd0, 1'b0, 1'b1}},
      '{'{CMD_INSERT, 32'h8000_0000, 16'h8000}, 1'b0, '0},
      '{'{CMD_INSERT, 32'h7FFF_FFFF, 16'h7FFF}, 1'b0, '0},
      '{'{CMD_CLEAR, 32'h0000_0000, 16'hFFFF}, 1'b0, '0}
   };

   sorted_priority_queue_top dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_key          (req_key),
      .req_tag          (req_tag),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_accepted     (rsp_accepted),
      .rsp_served_valid (rsp_served_valid),
      .rsp_served_key   (rsp_served_key),
      .rsp_served_tag   (rsp_served_tag),
      .rsp_head_key     (rsp_head_key),
      .rsp_head_tag     (rsp_head_tag),
      .rsp_occupancy    (rsp_occupancy),
      .rsp_is_full      (rsp_is_full),
      .rsp_is_empty     (rsp_is_empty)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic queue_status_type advance_queue(input queue_op_type op);
      queue_status_type s;
      int limit;
      int pos;
      s = '0;
      limit = (model_capacity > DEPTH) ? DEPTH : int'(model_capacity);
      case (op.cmd)
         CMD_INSERT: begin
            if (held_count < limit) begin
               pos = 0;
               while (pos < held_count && held_keys[pos] <= op.key) pos++;
               for (int j = held_count; j > pos; j--) begin
                  held_keys[j] = held_keys[j-1];
                  held_tags[j] = held_tags[j-1];
               end
               held_keys[pos] = op.key;
               held_tags[pos] = op.tag;
               held_count++;
               s.accepted = 1'b1;
            end
         end
         CMD_SERVE: begin
            if (held_count > 0) begin
               s.served_valid = 1'b1;
               s.served_key = held_keys[0];
               s.served_tag = held_tags[0];
               for (int j = 0; j + 1 < held_count; j++) begin
                  held_keys[j] = held_keys[j+1];
                  held_tags[j] = held_tags[j+1];
               end
               held_count--;
            end
         end
         CMD_CLEAR: held_count = 0;
         CMD_NOP: ;
         default: ;
      endcase
      if (held_count > 0) begin
         s.head_key = held_keys[0];
         s.head_tag = held_tags[0];
      end
      s.occupancy = OCC_W'(held_count);
      s.is_full = held_count >= limit;
      s.is_empty = held_count == 0;
      return s;
   endfunction

   function automatic queue_op_type random_op(input int insert_pct);
      queue_op_type op;
      int r;
      r = $urandom_range(0, 99);
      op.key = $urandom();
      op.tag = TAG_W'($urandom_range(0, 65535));
      if (r < insert_pct) begin
         op.cmd = CMD_INSERT;
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: op.key = KEY_W'($urandom_range(0, 20));
            8: op.key = '0;
            9: op.key = '1;
            default: ;
         endcase
      end else if (r < 94) begin
         op.cmd = CMD_SERVE;
      end else if (r < 97) begin
         op.cmd = CMD_NOP;
      end else begin
         op.cmd = CMD_CLEAR;
      end
      return op;
   endfunction

   task automatic send_op(input queue_op_type op, input logic typed,
                          input queue_status_type status);
      int gap;
      queue_status_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= op.cmd;
      req_key <= op.key;
      req_tag <= op.tag;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = advance_queue(op);
      pending_status.push_back(typed ? status : predicted);
   endtask

   task automatic set_capacity(input logic [CAP_W-1:0] value);
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model_capacity = value;
   endtask

   task automatic note_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch on %s: expected %h, actual %h", name, want, got);
         end
      end
   endtask

   always @(posedge clock) begin : result_check
      queue_status_type got;
      queue_status_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_accepted, rsp_served_valid, rsp_served_key, rsp_served_tag,
                 rsp_head_key, rsp_head_tag, rsp_occupancy, rsp_is_full, rsp_is_empty};
         if (pending_status.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result word with nothing outstanding: %p", got);
            end
         end else begin
            want = pending_status.pop_front();
            note_field("accepted", 32'(want.accepted), 32'(got.accepted));
            note_field("served_valid", 32'(want.served_valid), 32'(got.served_valid));
            note_field("served_key", want.served_key, got.served_key);
            note_field("served_tag", 32'(want.served_tag), 32'(got.served_tag));
            note_field("head_key", want.head_key, got.head_key);
            note_field("head_tag", 32'(want.head_tag), 32'(got.head_tag));
            note_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
            note_field("is_full", 32'(want.is_full), 32'(got.is_full));
            note_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
         end
      end
   end

   always @(posedge clock) begin
      if (ready_hold > 0) begin
         rsp_ready <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 4) == 0) begin
            ready_hold <= pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int insert_pct;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (opening_ops[i]) begin
         send_op(opening_ops[i].op, opening_ops[i].typed, opening_ops[i].status);
      end
      for (int p = 0; p < PHASES; p++) begin
         set_capacity(phase_caps[p]);
         steady = ($urandom_range(0, 3) == 0);
         insert_pct = $urandom_range(35, 80);
         for (int n = 0; n < WORDS_PER_PHASE; n++) begin
            send_op(random_op(insert_pct), 1'b0, '0);
         end
      end
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
